// File: hdl/tks_pkg.sv
package tks_pkg;

  // Default table shape
  localparam int DEF_ENTRIES   = 10;
  localparam int DEF_TAG_WIDTH = 16;

  // Fixed field widths
  localparam int SCORE_W    = 31;
  localparam int PORT_TAG_W = 16;
  localparam int CMD_W      = 2;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_RANK   = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

endpackage

// File: hdl/tks_mem.sv
module tks_mem #(
  parameter int DEPTH = tks_pkg::DEF_ENTRIES,
  parameter int WIDTH = tks_pkg::SCORE_W + tks_pkg::DEF_TAG_WIDTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write one word per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read word, hold it between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/top_k_score_table_core.sv
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+------------------------------------------
// in       | input     | in_valid_i / in_stall_o  | command_i, score_i, player_tag_i, slot_i
// out      | output    | out_valid_o / out_stall_i| position_o, entry_score_o, entry_player_o,
//          |           |                          | entry_valid_o, fill_count_o
//
// Insert and rank query walk the table from the last held entry upward, one memory
// read per cycle, and stop at the first entry that stays ahead or at the top entry.
// A read or an unused command goes straight from idle to the final step.
// Inserts shift entries down by one slot as the walk passes them.
// rst_ni clears the count and the control state; the memory holds no reset.
// A result waits in the output register under out_stall_i; the next transaction is
// taken meanwhile and its last step waits until the output register is free.
module top_k_score_table_core #(
  parameter int ENTRIES   = tks_pkg::DEF_ENTRIES,
  parameter int TAG_WIDTH = tks_pkg::DEF_TAG_WIDTH,
  localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W  = $clog2(ENTRIES + 1),
  localparam int POS_W  = (CNT_W > 4) ? CNT_W : 4,
  localparam int SLOT_W = (AW > 4) ? AW : 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tks_pkg::CMD_W-1:0]      command_i,
  input  logic [tks_pkg::SCORE_W-1:0]    score_i,
  input  logic [tks_pkg::PORT_TAG_W-1:0] player_tag_i,
  input  logic [SLOT_W-1:0]              slot_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [POS_W-1:0]               position_o,
  output logic [tks_pkg::SCORE_W-1:0]    entry_score_o,
  output logic [tks_pkg::PORT_TAG_W-1:0] entry_player_o,
  output logic                           entry_valid_o,
  output logic [POS_W-1:0]               fill_count_o
);

  localparam int TW = (TAG_WIDTH < tks_pkg::PORT_TAG_W) ? TAG_WIDTH : tks_pkg::PORT_TAG_W;
  localparam int WORD_W = tks_pkg::SCORE_W + TW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e                        state_q;
  tks_pkg::cmd_e                 cmd_q;
  logic [tks_pkg::SCORE_W-1:0]   score_q;
  logic [TW-1:0]                 tag_q;
  logic                          hit_q;
  logic [CNT_W-1:0]              p_q;
  logic [CNT_W-1:0]              count_q;
  logic                          out_valid_q;
  logic [POS_W-1:0]              position_q;
  logic [tks_pkg::SCORE_W-1:0]   entry_score_q;
  logic [tks_pkg::PORT_TAG_W-1:0] entry_player_q;
  logic                          entry_valid_q;

  logic                          accept;
  logic                          hit;
  logic                          out_free;
  logic                          stop;
  logic                          scan_cmd;
  logic [WORD_W-1:0]             rd_data;
  logic [tks_pkg::SCORE_W-1:0]   rd_score;
  logic [TW-1:0]                 rd_tag;
  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [WORD_W-1:0]             wr_data;
  logic [CNT_W-1:0]              count_m1;
  logic [CNT_W-1:0]              p_m2;
  logic                          p_in_table;
  logic [POS_W-1:0]              fin_position;
  logic [tks_pkg::SCORE_W-1:0]   fin_score;
  logic [tks_pkg::PORT_TAG_W-1:0] fin_player;
  logic                          fin_valid;
  logic [CNT_W-1:0]              fin_count;

  tks_mem #(
    .DEPTH(ENTRIES),
    .WIDTH(WORD_W)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign rd_score = rd_data[WORD_W-1 -: tks_pkg::SCORE_W];
  assign rd_tag   = rd_data[TW-1:0];

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hit        = 32'(slot_i) < 32'(count_q);
  assign scan_cmd   = (command_i == tks_pkg::CMD_INSERT) || (command_i == tks_pkg::CMD_RANK);
  assign count_m1   = count_q - CNT_W'(1);
  assign p_m2       = p_q - CNT_W'(2);
  assign p_in_table = p_q < CNT_W'(ENTRIES);

  // Insert stops at an entry with equal or higher score, rank only at a higher one
  always_comb begin
    if (cmd_q == tks_pkg::CMD_INSERT) begin
      stop = rd_score >= score_q;
    end else begin
      stop = rd_score > score_q;
    end
  end

  // Issue reads: last held entry on start, next entry up while walking, slot on read
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept && scan_cmd && (count_q != '0)) begin
      rd_en   = 1'b1;
      rd_addr = count_m1[AW-1:0];
    end else if (accept && (command_i == tks_pkg::CMD_READ) && hit) begin
      rd_en   = 1'b1;
      rd_addr = slot_i[AW-1:0];
    end else if ((state_q == S_SCAN) && !stop && (p_q > CNT_W'(1))) begin
      rd_en   = 1'b1;
      rd_addr = p_m2[AW-1:0];
    end
  end

  // Shift passed entries down one slot, then drop the new pair into the gap
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_q[AW-1:0];
    wr_data = rd_data;
    if ((state_q == S_SCAN) && (cmd_q == tks_pkg::CMD_INSERT) && !stop && p_in_table) begin
      wr_en = 1'b1;
    end else if ((state_q == S_FIN) && out_free && (cmd_q == tks_pkg::CMD_INSERT) &&
                 p_in_table) begin
      wr_en   = 1'b1;
      wr_data = {score_q, tag_q};
    end
  end

  // Form the result of the finished transaction
  always_comb begin
    fin_position = '0;
    fin_score    = '0;
    fin_player   = '0;
    fin_valid    = 1'b0;
    fin_count    = count_q;
    unique case (cmd_q)
      tks_pkg::CMD_INSERT: begin
        if (p_in_table) begin
          fin_position = POS_W'(p_q + CNT_W'(1));
        end
        if (count_q < CNT_W'(ENTRIES)) begin
          fin_count = count_q + CNT_W'(1);
        end
      end
      tks_pkg::CMD_RANK: begin
        if (p_in_table) begin
          fin_position = POS_W'(p_q + CNT_W'(1));
        end
      end
      tks_pkg::CMD_READ: begin
        if (hit_q) begin
          fin_score  = rd_score;
          fin_player = tks_pkg::PORT_TAG_W'(rd_tag);
          fin_valid  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequence the walk and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cmd_q          <= tks_pkg::CMD_INSERT;
      score_q        <= '0;
      tag_q          <= '0;
      hit_q          <= 1'b0;
      p_q            <= '0;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
      position_q     <= '0;
      entry_score_q  <= '0;
      entry_player_q <= '0;
      entry_valid_q  <= 1'b0;
    end else begin
      // Drop the taken result unless the final step reloads the register
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= tks_pkg::cmd_e'(command_i);
            score_q <= score_i;
            tag_q   <= player_tag_i[TW-1:0];
            hit_q   <= hit;
            if (scan_cmd && (count_q != '0)) begin
              p_q     <= count_q;
              state_q <= S_SCAN;
            end else begin
              p_q     <= '0;
              state_q <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (stop) begin
            state_q <= S_FIN;
          end else begin
            p_q <= p_q - CNT_W'(1);
            if (p_q == CNT_W'(1)) begin
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            position_q     <= fin_position;
            entry_score_q  <= fin_score;
            entry_player_q <= fin_player;
            entry_valid_q  <= fin_valid;
            count_q        <= fin_count;
            state_q        <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = position_q;
  assign entry_score_o  = entry_score_q;
  assign entry_player_o = entry_player_q;
  assign entry_valid_o  = entry_valid_q;
  assign fill_count_o   = POS_W'(count_q);

  // The count moves only when an insert completes
  a_count_on_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q == S_FIN && cmd_q == tks_pkg::CMD_INSERT))
    else $error("count changed outside an insert");

  // The walk stays inside the held entries
  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((p_q != '0) && (p_q <= count_q)))
    else $error("walk index outside held entries");

  // A result appears only from the final step
  a_result_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the final step");

endmodule
